FILE: rtl/spq_pkg.sv
// Shared constants, codes and transfer types of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 16;
  localparam int ITEM_BITS = 8;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                 cmd;
    logic [15:0]          arrival_time;
    logic [ITEM_BITS-1:0] item_id;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 front_valid;
    logic [15:0]          front_time;
    logic [ITEM_BITS-1:0] front_item;
    logic [CNT_BITS-1:0]  occupancy;
  } spq_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       apply;
    logic       enq_commit;
    logic       deq_commit;
    logic [1:0] status;
  } spq_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_deq;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

FILE: rtl/spq_datapath.sv
// Shift-register entry chain, request holding register and result register.
module spq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::spq_in_t  request,
  input  spq_pkg::spq_ctrl_t ctrl,
  output spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_out_t result
);

  spq_pkg::spq_in_t req;

  logic [spq_pkg::KEY_BITS-1:0]  keys [spq_pkg::DEPTH];
  logic [spq_pkg::ITEM_BITS-1:0] items [spq_pkg::DEPTH];
  logic [spq_pkg::KEY_BITS-1:0]  keys_next [spq_pkg::DEPTH];
  logic [spq_pkg::ITEM_BITS-1:0] items_next [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_BITS-1:0]  count;
  logic [spq_pkg::CNT_BITS-1:0]  count_next;
  logic [spq_pkg::DEPTH-1:0]     gt;
  logic [spq_pkg::KEY_BITS-1:0]  new_key;

  assign new_key = req.arrival_time[spq_pkg::KEY_BITS-1:0];

  assign stat.req_deq = (req.cmd == spq_pkg::OP_DEQ);
  assign stat.full    = (count == spq_pkg::CNT_BITS'(spq_pkg::DEPTH));
  assign stat.empty   = (count == '0);

  // Only held entries compare; the held region is sorted, so gt is a run of ones.
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      gt[i] = (spq_pkg::CNT_BITS'(i) < count) && (keys[i] > new_key);
    end
  end

  always_comb begin
    count_next = count;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      keys_next[i]  = keys[i];
      items_next[i] = items[i];
    end
    if (ctrl.enq_commit) begin
      count_next = count + 1'b1;
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          keys_next[i]  = keys[(i > 0) ? i - 1 : 0];
          items_next[i] = items[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || spq_pkg::CNT_BITS'(i) == count) begin
          keys_next[i]  = new_key;
          items_next[i] = req.item_id;
        end
      end
    end else if (ctrl.deq_commit) begin
      count_next = count - 1'b1;
      for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
        keys_next[i]  = keys[i + 1];
        items_next[i] = items[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req <= request;
    end
    if (ctrl.apply) begin
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
        keys[i]  <= keys_next[i];
        items[i] <= items_next[i];
      end
      result.status      <= ctrl.status;
      result.occupancy   <= count_next;
      result.front_valid <= (count_next != '0);
      result.front_time  <= (count_next != '0) ? 16'(keys_next[0]) : '0;
      result.front_item  <= (count_next != '0) ? items_next[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.apply) begin
      count <= count_next;
    end
  end

endmodule

FILE: rtl/spq_controller.sv
// Sequencer: takes a request, decides its outcome, and applies it.
module spq_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctrl_t ctrl,
  output logic               busy,
  output logic               done
);

  typedef enum logic {S_IDLE, S_APPLY} state_t;

  state_t state;

  always_comb begin
    ctrl            = '0;
    ctrl.status     = spq_pkg::ST_OK;
    ctrl.load       = (state == S_IDLE) && start;
    if (state == S_APPLY) begin
      ctrl.apply = 1'b1;
      if (stat.req_deq) begin
        if (stat.empty) begin
          ctrl.status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.deq_commit = 1'b1;
        end
      end else begin
        if (stat.full) begin
          ctrl.status = spq_pkg::ST_FULL;
        end else begin
          ctrl.enq_commit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_APPLY;
            busy  <= 1'b1;
          end
        end
        S_APPLY: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue: up to 16 entries of item handle and time key, kept in key order.
//
// A request is transferred when start is high and busy is low. busy then stays high while
// the entry chain updates, and the result shows on result with done high for exactly one
// cycle after that; the receiver must take it then. A new request may be transferred in
// the same cycle that done is high, but none is taken while busy is high. The block first
// captures the request, then every entry of the shift-register chain compares with the
// new key and shifts in parallel. Enqueues insert after all entries of equal key; an
// enqueue on a full queue is dropped with status full, a dequeue on an empty queue reports
// status empty. With the queue empty, front_time and front_item read zero.
module sorted_priority_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spq_pkg::spq_in_t  request,
  output logic              busy,
  output logic              done,
  output spq_pkg::spq_out_t result
);

  spq_pkg::spq_ctrl_t ctrl;
  spq_pkg::spq_stat_t stat;

  spq_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  spq_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .stat    (stat),
    .result  (result)
  );

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("transferred request did not start an update");

  a_front_matches_occ: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.front_valid == (result.occupancy != '0)))
    else $error("front flag disagrees with occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.occupancy <= spq_pkg::CNT_BITS'(spq_pkg::DEPTH)))
    else $error("occupancy beyond capacity");
`endif

endmodule

FILE: bench/spq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted priority queue: shadow entry chain and pending result checks.
package spq_scoreboard_pkg;
  import spq_pkg::*;

  class spq_scoreboard;
    logic [KEY_BITS-1:0]  shadow_keys [DEPTH];
    logic [ITEM_BITS-1:0] shadow_items [DEPTH];
    int                   shadow_count;
    spq_out_t             front_expect_q[$];
    int                   errors;

    function new();
      shadow_count = 0;
      errors       = 0;
    endfunction

    function int pending();
      return front_expect_q.size();
    endfunction

    // Apply one transferred request to the shadow chain and queue the result it implies.
    function void note_request(spq_in_t req);
      spq_out_t            want;
      logic [KEY_BITS-1:0] key;
      int                  pos;
      want   = '0;
      key    = req.arrival_time[KEY_BITS-1:0];
      want.status = ST_OK;
      if (req.cmd == OP_ENQ) begin
        if (shadow_count >= DEPTH) begin
          want.status = ST_FULL;
        end else begin
          // insert ahead of the first strictly greater key, so equal keys keep arrival order
          pos = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (pos == shadow_count && shadow_keys[i] > key) pos = i;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i]  = shadow_keys[i-1];
            shadow_items[i] = shadow_items[i-1];
          end
          shadow_keys[pos]  = key;
          shadow_items[pos] = req.item_id;
          shadow_count++;
        end
      end else begin
        if (shadow_count == 0) begin
          want.status = ST_EMPTY;
        end else begin
          for (int i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1]  = shadow_keys[i];
            shadow_items[i-1] = shadow_items[i];
          end
          shadow_count--;
        end
      end
      if (shadow_count > 0) begin
        want.front_valid = 1'b1;
        want.front_time  = 16'(shadow_keys[0]);
        want.front_item  = shadow_items[0];
      end
      want.occupancy = shadow_count[CNT_BITS-1:0];
      front_expect_q.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(spq_out_t got);
      spq_out_t want;
      if (front_expect_q.size() == 0) begin
        report("result with no request pending", 32'(got), 32'd0);
      end else begin
        want = front_expect_q.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.front_valid !== want.front_valid)
          report("front_valid", 32'(got.front_valid), 32'(want.front_valid));
        if (got.front_time !== want.front_time)
          report("front_time", 32'(got.front_time), 32'(want.front_time));
        if (got.front_item !== want.front_item)
          report("front_item", 32'(got.front_item), 32'(want.front_item));
        if (got.occupancy !== want.occupancy)
          report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
    endtask
  endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives random and directed queue requests and checks every result.
module tb_top;
  import spq_pkg::*;
  import spq_scoreboard_pkg::*;

  localparam int STALL_LIMIT   = 500;
  localparam int BLOCK_ITEMS   = 61;
  localparam int RANDOM_BLOCKS = 30;

  logic     clk;
  logic     rst;
  logic     start;
  spq_in_t  request;
  logic     busy;
  logic     done;
  spq_out_t result;

  spq_scoreboard sb;
  int            idle_cycles;
  logic          burst_mode;

  sorted_priority_queue_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Check each result in the cycle its strobe is high.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Watchdog: end the run when no transfer of either kind happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Hold the request until the block takes it, after an optional random gap.
  task send_request(logic op, logic [15:0] key, logic [ITEM_BITS-1:0] id);
    spq_in_t req;
    int      gap;
    req.cmd          = op;
    req.arrival_time = key;
    req.item_id      = id;
    gap = burst_mode ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // Hold off until every pending result has come back.
  task drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [15:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535)) | 16'hFF00;
    endcase
  endfunction

  initial begin
    int enq_pct;
    sb          = new();
    burst_mode  = 1'b0;
    idle_cycles = 0;
    rst         <= 1'b1;
    start       <= 1'b0;
    request     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, key and handle extremes, equal keys, full drop.
    send_request(OP_DEQ, 16'hFFFF, 8'hFF);
    send_request(OP_ENQ, 16'hFFFF, 8'hFF);
    send_request(OP_ENQ, 16'h0000, 8'h00);
    send_request(OP_ENQ, 16'h8000, 8'hAA);
    send_request(OP_ENQ, 16'h8000, 8'h55);
    send_request(OP_ENQ, 16'h8000, 8'h0F);
    send_request(OP_ENQ, 16'h0000, 8'hF0);
    for (int i = 0; i < 10; i++)
      send_request(OP_ENQ, 16'(16'h1919 * i), 8'($urandom_range(0, 255)));
    send_request(OP_ENQ, 16'h0000, 8'h33);
    send_request(OP_ENQ, 16'hFFFF, 8'hCC);
    repeat (3) send_request(OP_DEQ, 16'h0000, 8'h00);
    drain_results();

    // Random: each block leans toward filling, churning or emptying the queue.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        send_request(($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ,
                     pick_key(), 8'($urandom_range(0, 255)));
      end
      if (blk % 6 == 5) drain_results();
    end
    burst_mode = 1'b0;
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
